// File: rtl/iksl_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iksl_pkg
// Shared types and codes for the keyed slot table: request and status codes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package iksl_pkg;

    localparam int KEY_W    = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 6;
    localparam int PORT_PAY_W = 32;
    localparam int FILL_OUT_W = 7;
    localparam int CAP_W    = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_DELETE = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_RDREQ = 2'd2,
        S_RDFIN = 2'd3
    } t_state;

    typedef struct packed {
        logic load_req;
        logic scan_step;
        logic finish_scan;
        logic read_issue;
        logic finish_read;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: rtl/iksl_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iksl_ctrl
// Sequencer for the keyed slot table. Accepts a request, steps the datapath
// through its slot scan or slot read and tells it when to finish.
// ---------------------------------------------------------------------------
module iksl_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire logic [iksl_pkg::FUNC_W-1:0] i_func,
    input  wire iksl_pkg::t_dp_stat     i_stat,
    output iksl_pkg::t_dp_cmd           o_cmd,
    output logic                        busy
);

    iksl_pkg::t_state r_state;
    iksl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iksl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            iksl_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load_req = 1'b1;
                    if (i_func == iksl_pkg::FN_READ) begin
                        n_state = iksl_pkg::S_RDREQ;
                    end else begin
                        n_state = iksl_pkg::S_SCAN;
                    end
                end
            end
            iksl_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    o_cmd.finish_scan = 1'b1;
                    n_state = iksl_pkg::S_IDLE;
                end
            end
            iksl_pkg::S_RDREQ: begin
                o_cmd.read_issue = 1'b1;
                n_state = iksl_pkg::S_RDFIN;
            end
            iksl_pkg::S_RDFIN: begin
                o_cmd.finish_read = 1'b1;
                n_state = iksl_pkg::S_IDLE;
            end
            default: begin
                n_state = iksl_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/iksl_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iksl_dp
// Datapath of the keyed slot table: entry memory, live marks, fill count,
// capacity register, scan pointer and the registered result.
// ---------------------------------------------------------------------------
module iksl_dp #(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [iksl_pkg::CAP_W-1:0]        i_cfg_wdata,
    input  wire logic [iksl_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [iksl_pkg::KEY_W-1:0]        i_key_id,
    input  wire logic [iksl_pkg::PORT_PAY_W-1:0]   i_payload_in,
    input  wire logic [iksl_pkg::IDX_W-1:0]        i_slot_index,
    input  wire iksl_pkg::t_dp_cmd                 i_cmd,
    output iksl_pkg::t_dp_stat                     o_stat,
    output logic                                   o_done,
    output logic [iksl_pkg::STATUS_W-1:0]          o_status,
    output logic [iksl_pkg::IDX_W-1:0]             o_slot_out,
    output logic [iksl_pkg::KEY_W-1:0]             o_id_out,
    output logic [iksl_pkg::PORT_PAY_W-1:0]        o_payload_out,
    output logic                                   o_live_out,
    output logic [iksl_pkg::FILL_OUT_W-1:0]        o_fill_out
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);
    localparam int EW = iksl_pkg::KEY_W + PAYLOAD_BITS;

    logic [EW-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_live;
    logic [FW-1:0] r_fill;
    logic [iksl_pkg::CAP_W-1:0] r_cap;

    logic [iksl_pkg::FUNC_W-1:0] r_req_func;
    logic [iksl_pkg::KEY_W-1:0] r_req_key;
    logic [PAYLOAD_BITS-1:0] r_req_pay;
    logic [iksl_pkg::IDX_W-1:0] r_req_idx;

    logic [FW-1:0] r_scan_cnt;
    logic r_rd_vld;
    logic [AW-1:0] r_rd_addr;
    logic [EW-1:0] r_rd_data;
    logic r_rd_live;

    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic scan_hit;
    logic scan_more;
    logic in_range;
    logic tbl_full;
    logic wr_en;
    logic del_en;
    logic fin;

    logic r_done;
    logic [iksl_pkg::STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0] r_slot, n_slot;
    logic [iksl_pkg::KEY_W-1:0] r_id, n_id;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic r_live_o, n_live_o;
    logic [FW-1:0] n_fill;

    assign scan_hit = r_rd_vld && r_rd_live &&
                      (r_rd_data[PAYLOAD_BITS +: iksl_pkg::KEY_W] == r_req_key);
    assign scan_more = (32'(r_scan_cnt) < 32'(r_fill)) && !scan_hit;
    assign o_stat.scan_end = scan_hit || (32'(r_scan_cnt) >= 32'(r_fill));
    assign in_range = 32'(r_req_idx) < 32'(r_fill);
    assign tbl_full = (32'(r_fill) >= 32'(r_cap)) || (32'(r_fill) >= SLOTS);
    assign fin = i_cmd.finish_scan || i_cmd.finish_read;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_scan_cnt[AW-1:0];
        if (i_cmd.read_issue) begin
            rd_en   = in_range;
            rd_addr = AW'(r_req_idx);
        end else if (i_cmd.scan_step) begin
            rd_en = scan_more;
        end
    end

    // Result of the finishing step; a non-ok status leaves every field zero.
    always_comb begin
        n_status = iksl_pkg::ST_OK;
        n_slot   = '0;
        n_id     = '0;
        n_pay    = '0;
        n_live_o = 1'b0;
        n_fill   = r_fill;
        wr_en    = 1'b0;
        del_en   = 1'b0;
        if (i_cmd.finish_read) begin
            if (in_range) begin
                n_slot   = AW'(r_req_idx);
                n_id     = r_rd_data[PAYLOAD_BITS +: iksl_pkg::KEY_W];
                n_pay    = r_rd_data[PAYLOAD_BITS-1:0];
                n_live_o = r_rd_live;
            end else begin
                n_status = iksl_pkg::ST_RANGE;
            end
        end else if (r_req_func == iksl_pkg::FN_ADD) begin
            if (scan_hit) begin
                n_status = iksl_pkg::ST_DUP;
            end else if (tbl_full) begin
                n_status = iksl_pkg::ST_FULL;
            end else begin
                wr_en    = i_cmd.finish_scan;
                n_slot   = r_fill[AW-1:0];
                n_id     = r_req_key;
                n_pay    = r_req_pay;
                n_live_o = 1'b1;
                n_fill   = r_fill + FW'(1);
            end
        end else begin
            if (scan_hit) begin
                n_slot   = r_rd_addr;
                n_id     = r_rd_data[PAYLOAD_BITS +: iksl_pkg::KEY_W];
                n_pay    = r_rd_data[PAYLOAD_BITS-1:0];
                n_live_o = (r_req_func != iksl_pkg::FN_DELETE);
                del_en   = i_cmd.finish_scan && (r_req_func == iksl_pkg::FN_DELETE);
            end else begin
                n_status = iksl_pkg::ST_MISSING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= {r_req_key, r_req_pay};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_func <= i_func;
            r_req_key  <= i_key_id;
            r_req_pay  <= PAYLOAD_BITS'(i_payload_in);
            r_req_idx  <= i_slot_index;
        end
        if (rd_en) begin
            r_rd_addr <= rd_addr;
            r_rd_live <= r_live[rd_addr];
        end
        if (fin) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_id     <= n_id;
            r_pay    <= n_pay;
            r_live_o <= n_live_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_fill     <= '0;
            r_cap      <= iksl_pkg::CAP_RESET;
            r_scan_cnt <= '0;
            r_rd_vld   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done   <= fin;
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.load_req) begin
                r_scan_cnt <= '0;
            end else if (i_cmd.scan_step && scan_more) begin
                r_scan_cnt <= r_scan_cnt + FW'(1);
            end
            if (wr_en) begin
                r_live[r_fill[AW-1:0]] <= 1'b1;
            end
            if (del_en) begin
                r_live[r_rd_addr] <= 1'b0;
            end
            if (fin) begin
                r_fill <= n_fill;
            end
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_out    = iksl_pkg::IDX_W'(r_slot);
    assign o_id_out      = r_id;
    assign o_payload_out = iksl_pkg::PORT_PAY_W'(r_pay);
    assign o_live_out    = r_live_o;
    assign o_fill_out    = iksl_pkg::FILL_OUT_W'(r_fill);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= SLOTS)
        else $error("fill count exceeds the number of slots");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (r_fill == $past(r_fill) + FW'(1)) && $past(wr_en))
        else $error("fill count moved other than by one add");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> o_done)
        else $error("finishing step gave no result strobe");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != iksl_pkg::ST_OK)) |->
        (o_slot_out == '0) && (o_id_out == '0) && (o_payload_out == '0) && !o_live_out)
        else $error("result fields not cleared on a failed request");

    a_scan_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (32'(r_rd_addr) < 32'(r_fill)))
        else $error("slot read beyond the filled region");

endmodule
`default_nettype wire

// File: rtl/id_keyed_slot_table_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// id_keyed_slot_table_core
// Keyed slot table with append-only allocation and tombstone deletion.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its one result
// appears on the o_ result ports for a single cycle with o_done high; the
// receiver cannot hold it off, so it must take every strobe. Add, lookup and
// delete walk the filled slots through the single read port of the entry
// memory, one slot per cycle, and a match stops the walk early; read-by-slot
// reads the one slot named by i_slot_index. The next request may be offered
// in the same cycle as the previous result strobe. The user must write the
// capacity register through i_cfg_we and i_cfg_wdata only while the block is
// idle; the block itself does not enforce this. No reset pass is needed, the
// block is ready straight after reset.
// ---------------------------------------------------------------------------
module id_keyed_slot_table_core #(
    parameter int SLOTS        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [iksl_pkg::CAP_W-1:0]        i_cfg_wdata,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [iksl_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [iksl_pkg::KEY_W-1:0]        i_key_id,
    input  wire logic [iksl_pkg::PORT_PAY_W-1:0]   i_payload_in,
    input  wire logic [iksl_pkg::IDX_W-1:0]        i_slot_index,
    output logic                                   o_done,
    output logic [iksl_pkg::STATUS_W-1:0]          o_status,
    output logic [iksl_pkg::IDX_W-1:0]             o_slot_out,
    output logic [iksl_pkg::KEY_W-1:0]             o_id_out,
    output logic [iksl_pkg::PORT_PAY_W-1:0]        o_payload_out,
    output logic                                   o_live_out,
    output logic [iksl_pkg::FILL_OUT_W-1:0]        o_fill_out
);

    iksl_pkg::t_dp_cmd  dp_cmd;
    iksl_pkg::t_dp_stat dp_stat;

    iksl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    iksl_dp #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_func),
        .i_key_id      (i_key_id),
        .i_payload_in  (i_payload_in),
        .i_slot_index  (i_slot_index),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_id_out      (o_id_out),
        .o_payload_out (o_payload_out),
        .o_live_out    (o_live_out),
        .o_fill_out    (o_fill_out)
    );

endmodule
`default_nettype wire
